// ----- hw/rtl/bbc_pkg.sv -----
// Shared types and constants of the bracket balance checker.
// Depends on nothing; every other file of the block imports it.
package bbc_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int LINE_BITS   = 16;
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 3;
	localparam int KIND_W      = 2;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [CHAR_W-1:0]    char_t;
	typedef logic [LINE_BITS-1:0] line_t;
	typedef logic [DEPTH_W-1:0]   depth_t;

	localparam kind_t KIND_PAREN  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_BRACE  = 2'd2;
	localparam kind_t KIND_NONE   = 2'd3;

	localparam line_t LINE_MAX = {LINE_BITS{1'b1}};
	localparam line_t LINE_ONE = line_t'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_MISMATCH    = 3'd1,
		ST_EMPTY_CLOSE = 3'd2,
		ST_OVERFLOW    = 3'd3,
		ST_HALTED      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TOK_NONE  = 2'd0,
		TOK_OPEN  = 2'd1,
		TOK_CLOSE = 2'd2
	} tok_op_t;

	// Classified character handed from the lexer to the stack unit
	typedef struct packed {
		tok_op_t op;
		kind_t   kind;
		logic    newline;
	} token_t;

	localparam char_t CH_NL     = 8'h0A;
	localparam char_t CH_DQUOTE = 8'h22;
	localparam char_t CH_SQUOTE = 8'h27;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_LSQ    = 8'h5B;
	localparam char_t CH_BSLASH = 8'h5C;
	localparam char_t CH_RSQ    = 8'h5D;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_RBRACE = 8'h7D;

endpackage

// ----- hw/rtl/bbc_if.sv -----
// Valid/ready channel interfaces of the bracket balance checker.
// Depends on bbc_pkg for field widths.
interface bbc_in_if;
	import bbc_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface bbc_out_if;
	import bbc_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	line_t               line_number;
	kind_t               open_kind;
	kind_t               close_kind;
	depth_t              nesting_depth;

	modport source (output valid, output status, output line_number, output open_kind,
		output close_kind, output nesting_depth, input ready);
	modport sink (input valid, input status, input line_number, input open_kind,
		input close_kind, input nesting_depth, output ready);
endinterface

// ----- hw/rtl/bbc_lexer.sv -----
// Front part: accepts characters, tracks comment/quote mode and escapes,
// and classifies each character into a token. Depends on bbc_pkg, bbc_if.
module bbc_lexer (
	input  logic            clk,
	input  logic            arst_n,
	bbc_in_if.sink          char_in,
	output logic            tok_valid,
	output bbc_pkg::token_t tok,
	input  logic            tok_ready
);
	import bbc_pkg::*;

	typedef enum logic [6:0] {
		LX_NORMAL = 7'b0000001,
		LX_SLASH  = 7'b0000010,
		LX_LINE   = 7'b0000100,
		LX_BLOCK  = 7'b0001000,
		LX_STAR   = 7'b0010000,
		LX_SQUOTE = 7'b0100000,
		LX_DQUOTE = 7'b1000000
	} lex_mode_t;

	lex_mode_t mode_q, mode_d;
	logic      esc_q, esc_d;
	logic      run_code;
	tok_op_t   op;
	kind_t     kind;
	char_t     c;
	logic      accept;

	assign c      = char_in.char_code;
	assign accept = char_in.valid && tok_ready;

	always_comb begin
		mode_d   = mode_q;
		esc_d    = esc_q;
		run_code = 1'b0;
		op       = TOK_NONE;
		kind     = KIND_NONE;
		unique case (mode_q)
			LX_SLASH: begin
				if (c == CH_SLASH) begin
					mode_d = LX_LINE;
				end else if (c == CH_STAR) begin
					mode_d = LX_BLOCK;
				end else begin
					mode_d   = LX_NORMAL;
					run_code = 1'b1;
				end
			end
			LX_LINE: begin
				if (c == CH_NL) mode_d = LX_NORMAL;
			end
			LX_BLOCK: begin
				if (c == CH_STAR) mode_d = LX_STAR;
			end
			LX_STAR: begin
				// a run of stars keeps the closing state
				if (c == CH_SLASH) begin
					mode_d = LX_NORMAL;
				end else if (c != CH_STAR) begin
					mode_d = LX_BLOCK;
				end
			end
			LX_SQUOTE, LX_DQUOTE: begin
				if (esc_q) begin
					esc_d = 1'b0;
				end else if (c == CH_BSLASH) begin
					esc_d = 1'b1;
				end else if ((mode_q == LX_SQUOTE && c == CH_SQUOTE) ||
						(mode_q == LX_DQUOTE && c == CH_DQUOTE)) begin
					mode_d = LX_NORMAL;
				end
			end
			default: begin
				mode_d   = LX_NORMAL;
				run_code = 1'b1;
			end
		endcase

		if (run_code) begin
			if (esc_q) begin
				// drop the escaped character
				esc_d = 1'b0;
			end else begin
				unique case (c)
					CH_BSLASH: esc_d  = 1'b1;
					CH_SLASH:  mode_d = LX_SLASH;
					CH_SQUOTE: mode_d = LX_SQUOTE;
					CH_DQUOTE: mode_d = LX_DQUOTE;
					CH_LPAREN: begin op = TOK_OPEN;  kind = KIND_PAREN;  end
					CH_LSQ:    begin op = TOK_OPEN;  kind = KIND_SQUARE; end
					CH_LBRACE: begin op = TOK_OPEN;  kind = KIND_BRACE;  end
					CH_RPAREN: begin op = TOK_CLOSE; kind = KIND_PAREN;  end
					CH_RSQ:    begin op = TOK_CLOSE; kind = KIND_SQUARE; end
					CH_RBRACE: begin op = TOK_CLOSE; kind = KIND_BRACE;  end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LX_NORMAL;
			esc_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
		end
	end

	assign char_in.ready = tok_ready;
	assign tok_valid     = char_in.valid;
	assign tok.op        = op;
	assign tok.kind      = kind;
	assign tok.newline   = (c == CH_NL);

endmodule

// ----- hw/rtl/bbc_queue.sv -----
// Short token queue between lexer and stack unit; ready comes from a register.
// Depends on bbc_pkg.
module bbc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	input  bbc_pkg::token_t wr_data,
	output logic            wr_ready,
	output logic            rd_valid,
	output bbc_pkg::token_t rd_data,
	input  logic            rd_ready
);
	import bbc_pkg::*;

	token_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push, pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/bbc_stack_unit.sv -----
// Back part: bracket stack, line count, sticky error and the result register.
// The top two stack entries sit in registers; the rest live in a memory.
// Depends on bbc_pkg, bbc_if.
module bbc_stack_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  bbc_pkg::token_t tok,
	output logic            tok_ready,
	bbc_out_if.source       result_out
);
	import bbc_pkg::*;

	kind_t mem [STACK_DEPTH];

	logic    halted_q;
	depth_t  depth_q, depth_d;
	line_t   line_q, line_d;
	kind_t   top_q, top_d;
	kind_t   below_q, rd_q, below_cur;
	logic    below_mem_q;
	logic    push, pop, take;
	status_t status_d;
	kind_t   close_d, open_d;
	depth_t  rd_idx;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	line_t               line_out_q;
	kind_t               open_q, close_q;
	depth_t              depth_out_q;

	assign tok_ready = !out_valid_q || result_out.ready;
	assign take      = tok_valid && tok_ready;
	assign below_cur = below_mem_q ? rd_q : below_q;
	// entry that becomes second from top after a pop
	assign rd_idx    = depth_q - DEPTH_W'(3);

	always_comb begin
		status_d = ST_OK;
		close_d  = KIND_NONE;
		push     = 1'b0;
		pop      = 1'b0;
		line_d   = line_q;
		if (halted_q) begin
			status_d = ST_HALTED;
		end else begin
			if (tok.newline && line_q != LINE_MAX) line_d = line_q + LINE_ONE;
			unique case (tok.op)
				TOK_OPEN: begin
					if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
						status_d = ST_OVERFLOW;
					end else begin
						push = 1'b1;
					end
				end
				TOK_CLOSE: begin
					close_d = tok.kind;
					if (depth_q == '0) begin
						status_d = ST_EMPTY_CLOSE;
					end else if (top_q != tok.kind) begin
						status_d = ST_MISMATCH;
					end else begin
						pop = 1'b1;
					end
				end
				default: ;
			endcase
		end

		depth_d = depth_q;
		top_d   = top_q;
		if (push) begin
			depth_d = depth_q + DEPTH_W'(1);
			top_d   = tok.kind;
		end else if (pop) begin
			depth_d = depth_q - DEPTH_W'(1);
			top_d   = below_cur;
		end
		open_d = (depth_d == '0) ? KIND_NONE : top_d;
	end

	always_ff @(posedge clk) begin
		if (take && push) mem[depth_q[ADDR_W-1:0]] <= tok.kind;
		if (take && pop) rd_q <= mem[rd_idx[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			depth_q     <= '0;
			line_q      <= LINE_ONE;
			below_mem_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				halted_q    <= halted_q || (status_d != ST_OK);
				depth_q     <= depth_d;
				line_q      <= line_d;
				out_valid_q <= 1'b1;
				if (push) below_mem_q <= 1'b0;
				else if (pop) below_mem_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			top_q       <= top_d;
			if (push) below_q <= top_q;
			status_q    <= status_d;
			line_out_q  <= line_d;
			open_q      <= open_d;
			close_q     <= close_d;
			depth_out_q <= depth_d;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.status        = status_q;
	assign result_out.line_number   = line_out_q;
	assign result_out.open_kind     = open_q;
	assign result_out.close_kind    = close_q;
	assign result_out.nesting_depth = depth_out_q;

endmodule

// ----- hw/rtl/bracket_balance_checker.sv -----
// Bracket balance checker for C-style source text.
// Top level; depends on bbc_pkg, bbc_if, bbc_lexer, bbc_queue, bbc_stack_unit.
//
// char_in takes one source byte per item; result_out returns exactly one
// result per byte, in order: status, line number, top open bracket kind,
// closing bracket kind of this byte and nesting depth after the byte.
// Brackets in comments and in quoted literals are skipped; a backslash
// escapes the next byte. The first error makes the checker sticky-halted:
// every later byte answers halted with the state frozen.
// Throughput is one byte per cycle while the receiver does not stall: the lexer
// mode and the stack top each update on every accepted byte, and the stack
// memory is read one pop ahead so the entry below the top is always in a
// register. A byte accepted by the lexer is written into the queue, then moves
// into the result register, where it stays until the receiver takes it.
// A two-entry queue sits between lexer and stack unit, and the result
// register frees as it is taken, so input is accepted while a result waits.
// When the receiver stalls, the queue fills and char_in.ready drops.
// Reset clears mode, escape flag, depth, sticky error and sets the line to 1;
// the stack memory needs no clearing, since only pushed entries are read.
module bracket_balance_checker (
	input  logic      clk,
	input  logic      arst_n,
	bbc_in_if.sink    char_in,
	bbc_out_if.source result_out
);
	import bbc_pkg::*;

	logic   lx_valid, lx_ready;
	token_t lx_tok;
	logic   q_valid, q_ready;
	token_t q_tok;

	bbc_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.tok_valid (lx_valid),
		.tok       (lx_tok),
		.tok_ready (lx_ready)
	);

	bbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (lx_valid),
		.wr_data  (lx_tok),
		.wr_ready (lx_ready),
		.rd_valid (q_valid),
		.rd_data  (q_tok),
		.rd_ready (q_ready)
	);

	bbc_stack_unit u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (q_valid),
		.tok        (q_tok),
		.tok_ready  (q_ready),
		.result_out (result_out)
	);

	a_halted_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.status == ST_HALTED
		|-> result_out.close_kind == KIND_NONE)
		else $error("halted result carries a closing bracket");

	a_empty_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid
		|-> (result_out.nesting_depth == '0) == (result_out.open_kind == KIND_NONE))
		else $error("open kind disagrees with nesting depth");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> result_out.nesting_depth <= DEPTH_W'(STACK_DEPTH))
		else $error("nesting depth beyond stack size");

	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.ready && result_out.status != ST_OK &&
		result_out.status != ST_HALTED
		|=> !result_out.valid || result_out.status == ST_HALTED)
		else $error("item after an error not reported as halted");

endmodule
